[rtl/trs_pkg.sv]
// Shared widths, lane codes and register indexes for the plane truss
// element stiffness pipeline. No dependencies.
`default_nettype none

package trs_pkg;

  localparam int COORD_W    = 32;   // Q16.16 coordinate
  localparam int DELTA_W    = 33;   // node difference, signed
  localparam int SQ_W       = 66;   // dx*dx + dy*dy
  localparam int LEN_W      = 34;   // floor(sqrt(Q))
  localparam int COS_FRAC   = 30;   // cosine fraction bits
  localparam int COS_W      = 31;   // |c| <= 2^30
  localparam int PROD_W     = 62;   // cosine products
  localparam int EA_W       = 64;   // E*A
  localparam int MAG_W      = 64;   // result magnitude
  localparam int LANES      = 3;    // cc, cs, ss
  localparam int CFG_W      = 32;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 200;

  typedef enum logic [1:0] {
    LANE_CC = 2'd0,
    LANE_CS = 2'd1,
    LANE_SS = 2'd2
  } lane_t;

  typedef enum logic [0:0] {
    REG_YOUNG = 1'b0,
    REG_AREA  = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/trs_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside. Depends on nothing but its parameters.
`default_nettype none

module trs_sqrt #(
  parameter int RW = 34,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_rad,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output logic [SW-1:0]        out_side
);

  logic            v_s    [RW+1];
  logic [2*RW-1:0] rad_s  [RW+1];
  logic [RW+1:0]   rem_s  [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [SW-1:0]   side_s [RW+1];

  assign v_s[0]    = in_valid;
  assign rad_s[0]  = in_rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] rem2;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      rem2  = {rem_s[i][RW-1:0], rad_s[i][2*RW-1 -: 2]};
      trial = {root_s[i], 2'b01};
      ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[i+1]  <= {rad_s[i][2*RW-3:0], 2'b00};
        rem_s[i+1]  <= ge ? (rem2 - trial) : rem2;
        root_s[i+1] <= {root_s[i][RW-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = v_s[RW];
  assign out_root  = root_s[RW];
  assign out_side  = side_s[RW];

endmodule

`default_nettype wire

[rtl/trs_div.sv]
// Pipelined restoring divider: three numerators over one shared divisor,
// one quotient bit per stage. Uses trs_pkg for the lane count.
`default_nettype none

module trs_div
  import trs_pkg::*;
#(
  parameter int NW = 80,
  parameter int DW = 34,
  parameter int SW = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [LANES-1:0][NW-1:0] in_num,
  input  wire logic [DW-1:0]         in_den,
  input  wire logic [SW-1:0]         in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  // w holds the unconsumed numerator bits on top, quotient bits shift in below
  logic                     v_s    [NW+1];
  logic [LANES-1:0][NW-1:0] w_s    [NW+1];
  logic [LANES-1:0][DW-1:0] rem_s  [NW+1];
  logic [DW-1:0]            den_s  [NW+1];
  logic [SW-1:0]            side_s [NW+1];

  assign v_s[0]    = in_valid;
  assign w_s[0]    = in_num;
  assign rem_s[0]  = '0;
  assign den_s[0]  = in_den;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [LANES-1:0][DW:0]   rem2;
    logic [LANES-1:0][DW:0]   diff;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_n;
    logic [LANES-1:0][NW-1:0] w_n;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem2[l]  = {rem_s[i][l], w_s[i][l][NW-1]};
        diff[l]  = rem2[l] - {1'b0, den_s[i]};
        ge[l]    = (rem2[l] >= {1'b0, den_s[i]});
        rem_n[l] = ge[l] ? diff[l][DW-1:0] : rem2[l][DW-1:0];
        w_n[l]   = {w_s[i][l][NW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_s[i+1]    <= w_n;
        rem_s[i+1]  <= rem_n;
        den_s[i+1]  <= den_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = v_s[NW];
  assign out_quo   = w_s[NW];
  assign out_side  = side_s[NW];

endmodule

`default_nettype wire

[rtl/truss2d_element_stiffness.sv]
// Top level of the plane truss element stiffness pipeline.
// Depends on trs_pkg, trs_sqrt and trs_div.
//
//  channel  | dir | handshake          | payload (low bit up)
//  ---------+-----+--------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | node1_x, node1_y, node2_x, node2_y (32 each)
//  m_*      | out | m_tvalid/m_tready  | stiff_cc, stiff_cs, stiff_ss (64 each),
//           |     |                    | zero_length, saturated, 6 pad bits
//  cfg_*    | in  | cfg_we             | 0 young_modulus, 1 cross_area (32 bits)
//
// One beat per cycle sustained while the output is taken. Most of the depth is
// the divider: one quotient bit per stage over 64 + FRAC_BITS bits; the square
// root adds 34 stages, the front and back ends eleven. Reset clears all valid
// bits and loads E = A = 1.0. The whole pipe advances together; it holds only
// while the output register has a beat not taken.
`default_nettype none

module truss2d_element_stiffness
  import trs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // node1_x[31:0], node1_y[63:32], node2_x[95:64], node2_y[127:96]
  input  wire logic [IN_TDATA_W-1:0]   s_tdata,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // stiff_cc[63:0], stiff_cs[127:64], stiff_ss[191:128],
  // zero_length[192], saturated[193], zero[199:194]
  output logic [OUT_TDATA_W-1:0]       m_tdata,
  input  wire logic                    cfg_we,
  input  wire logic [0:0]              cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int KW   = EA_W + FRAC_BITS;   // k = floor(EA * 2^F / L)
  localparam int HI_W = KW - 64;            // top slice of k
  localparam int PW   = KW + COS_W + 1;     // k * m plus rounding
  localparam int SIDE_SQ = 2 * DELTA_W + 1;

  localparam logic [PROD_W-1:0] HALF_M   = PROD_W'(1) << (COS_FRAC - 1);
  localparam logic [95:0]       HALF_OUT = 96'(1) << (COS_FRAC - 1);
  localparam logic [MAG_W-1:0]  LIM_POS  = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic [MAG_W-1:0]  LIM_NEG  = {1'b1, {(MAG_W-1){1'b0}}};

  // pipeline advances whenever the output register is free or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // configuration
  logic [CFG_W-1:0] young_modulus;
  logic [CFG_W-1:0] cross_area;
  logic [EA_W-1:0]  ea;

  always_ff @(posedge clk) begin
    if (rst) begin
      young_modulus <= CFG_W'(65536);
      cross_area    <= CFG_W'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_YOUNG: young_modulus <= cfg_data;
        REG_AREA:  cross_area    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stable in flight if the user changes config only when idle; unchecked here
  always_ff @(posedge clk) begin
    ea <= EA_W'(young_modulus) * EA_W'(cross_area);
  end

  // A: node differences
  logic                       v_a;
  logic signed [DELTA_W-1:0]  dx_a, dy_a;
  logic signed [DELTA_W-1:0]  x1, y1, x2, y2;

  assign x1 = {s_tdata[31],  s_tdata[31:0]};
  assign y1 = {s_tdata[63],  s_tdata[63:32]};
  assign x2 = {s_tdata[95],  s_tdata[95:64]};
  assign y2 = {s_tdata[127], s_tdata[127:96]};

  // B: magnitudes and cs sign
  logic               v_b;
  logic [DELTA_W-1:0] adx_b, ady_b;
  logic               csneg_b;

  // C: squares
  logic               v_c;
  logic [SQ_W-1:0]    sqx_c, sqy_c;
  logic [DELTA_W-1:0] adx_c, ady_c;
  logic               csneg_c;

  // D: sum of squares
  logic               v_d;
  logic [SQ_W-1:0]    q_d;
  logic [DELTA_W-1:0] adx_d, ady_d;
  logic               csneg_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else if (en) begin
      v_a <= s_tvalid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a    <= x2 - x1;
      dy_a    <= y2 - y1;
      adx_b   <= dx_a[DELTA_W-1] ? DELTA_W'(-dx_a) : DELTA_W'(dx_a);
      ady_b   <= dy_a[DELTA_W-1] ? DELTA_W'(-dy_a) : DELTA_W'(dy_a);
      csneg_b <= dx_a[DELTA_W-1] ^ dy_a[DELTA_W-1];
      sqx_c   <= SQ_W'(adx_b) * SQ_W'(adx_b);
      sqy_c   <= SQ_W'(ady_b) * SQ_W'(ady_b);
      adx_c   <= adx_b;
      ady_c   <= ady_b;
      csneg_c <= csneg_b;
      q_d     <= sqx_c + sqy_c;
      adx_d   <= adx_c;
      ady_d   <= ady_c;
      csneg_d <= csneg_c;
    end
  end

  // length
  logic               v_l;
  logic [LEN_W-1:0]   len_l;
  logic [SIDE_SQ-1:0] side_l;

  trs_sqrt #(
    .RW (LEN_W),
    .SW (SIDE_SQ)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d),
    .in_rad    ({{(2*LEN_W-SQ_W){1'b0}}, q_d}),
    .in_side   ({csneg_d, ady_d, adx_d}),
    .out_valid (v_l),
    .out_root  (len_l),
    .out_side  (side_l)
  );

  // E: dividends with round-half-up folded in for the cosines
  logic                     v_e;
  logic [LANES-1:0][KW-1:0] num_e;
  logic [LEN_W-1:0]         len_e;
  logic                     csneg_e, zero_e;
  logic [DELTA_W-1:0]       adx_l, ady_l;
  logic [62:0]              cnum_l, snum_l;

  assign adx_l  = side_l[DELTA_W-1:0];
  assign ady_l  = side_l[2*DELTA_W-1:DELTA_W];
  assign cnum_l = {adx_l, {COS_FRAC{1'b0}}} + 63'(len_l >> 1);
  assign snum_l = {ady_l, {COS_FRAC{1'b0}}} + 63'(len_l >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else if (en) begin
      v_e <= v_l;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_e[0] <= KW'(cnum_l);
      num_e[1] <= KW'(snum_l);
      num_e[2] <= {ea, {FRAC_BITS{1'b0}}};
      len_e    <= len_l;
      csneg_e  <= side_l[SIDE_SQ-1];
      zero_e   <= (len_l == '0);
    end
  end

  // quotients: |c|, |s|, k
  logic                     v_q;
  logic [LANES-1:0][KW-1:0] quo_q;
  logic [1:0]               side_q;

  trs_div #(
    .NW (KW),
    .DW (LEN_W),
    .SW (2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_e),
    .in_num    (num_e),
    .in_den    (len_e),
    .in_side   ({zero_e, csneg_e}),
    .out_valid (v_q),
    .out_quo   (quo_q),
    .out_side  (side_q)
  );

  logic [COS_W-1:0] cm_q, sm_q;
  assign cm_q = quo_q[0][COS_W-1:0];
  assign sm_q = quo_q[1][COS_W-1:0];

  // F: cosine products, G: round to Q.30, H: k*m partials,
  // I/J: accumulate, K: clip, sign, output register
  logic                    v_f, v_g, v_h, v_i, v_j;
  logic [PROD_W-1:0]       p_f [LANES];
  logic [COS_W-1:0]        m_g [LANES];
  logic [KW-1:0]           k_f, k_g;
  logic [62:0]             pp0_h [LANES];
  logic [62:0]             pp1_h [LANES];
  logic [HI_W+COS_W-1:0]   pp2_h [LANES];
  logic [95:0]             s01_i [LANES];
  logic [HI_W+COS_W-1:0]   pp2_i [LANES];
  logic [PW-1:0]           tot_j [LANES];
  logic                    zero_f, zero_g, zero_h, zero_i, zero_j;
  logic                    csneg_f, csneg_g, csneg_h, csneg_i, csneg_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f      <= 1'b0;
      v_g      <= 1'b0;
      v_h      <= 1'b0;
      v_i      <= 1'b0;
      v_j      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v_f      <= v_q;
      v_g      <= v_f;
      v_h      <= v_g;
      v_i      <= v_h;
      v_j      <= v_i;
      m_tvalid <= v_j;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_f[LANE_CC] <= PROD_W'(cm_q) * PROD_W'(cm_q);
      p_f[LANE_CS] <= PROD_W'(cm_q) * PROD_W'(sm_q);
      p_f[LANE_SS] <= PROD_W'(sm_q) * PROD_W'(sm_q);
      k_f     <= quo_q[2];
      zero_f  <= side_q[1];
      csneg_f <= side_q[0];

      for (int l = 0; l < LANES; l++) begin
        m_g[l] <= COS_W'((p_f[l] + HALF_M) >> COS_FRAC);
      end
      k_g     <= k_f;
      zero_g  <= zero_f;
      csneg_g <= csneg_f;

      for (int l = 0; l < LANES; l++) begin
        pp0_h[l] <= 63'(k_g[31:0])  * 63'(m_g[l]);
        pp1_h[l] <= 63'(k_g[63:32]) * 63'(m_g[l]);
        pp2_h[l] <= (HI_W+COS_W)'(k_g[KW-1:64]) * (HI_W+COS_W)'(m_g[l]);
      end
      zero_h  <= zero_g;
      csneg_h <= csneg_g;

      for (int l = 0; l < LANES; l++) begin
        s01_i[l] <= 96'(pp0_h[l]) + (96'(pp1_h[l]) << 32) + HALF_OUT;
        pp2_i[l] <= pp2_h[l];
      end
      zero_i  <= zero_h;
      csneg_i <= csneg_h;

      for (int l = 0; l < LANES; l++) begin
        tot_j[l] <= PW'(s01_i[l]) + (PW'(pp2_i[l]) << 64);
      end
      zero_j  <= zero_i;
      csneg_j <= csneg_i;
    end
  end

  // clip and sign; only the cs lane can be negative
  logic [MAG_W-1:0] res_k [LANES];
  logic [LANES-1:0] sat_k;

  always_comb begin
    logic             neg;
    logic             hi;
    logic [MAG_W-1:0] low;
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] mag;
    for (int l = 0; l < LANES; l++) begin
      neg      = (l == int'(LANE_CS)) && csneg_j;
      hi       = |tot_j[l][PW-1:COS_FRAC+MAG_W];
      low      = tot_j[l][COS_FRAC+MAG_W-1:COS_FRAC];
      lim      = neg ? LIM_NEG : LIM_POS;
      sat_k[l] = hi || (low > lim);
      mag      = sat_k[l] ? lim : low;
      res_k[l] = neg ? (~mag + MAG_W'(1)) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_j) begin
        m_tdata <= {6'b0, 1'b0, 1'b1, {(3*MAG_W){1'b0}}};
      end else begin
        m_tdata <= {6'b0, |sat_k, 1'b0, res_k[LANE_SS], res_k[LANE_CS], res_k[LANE_CC]};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/trs_checker.sv]
// Port-level checks for truss2d_element_stiffness and the bind that
// attaches them. Depends on trs_pkg.
`default_nettype none

module trs_checker
  import trs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a held output beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // input side only stalls behind a blocked output beat
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // coinciding nodes give zeros and no clip
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[192] |-> m_tdata[191:0] == '0 && !m_tdata[193])
    else $error("zero-length beat with nonzero payload");

  // diagonal terms are never negative
  a_diag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[63] && !m_tdata[191])
    else $error("negative diagonal stiffness");

endmodule

bind truss2d_element_stiffness trs_checker u_trs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/truss2d_stiffness_checker.sv]
// Checker for the plane truss element stiffness pipeline: watches the node,
// result and register-write channels, predicts each result and compares it.
// Depends on trs_pkg.
`timescale 1ns / 100ps
`default_nettype none

module truss2d_stiffness_checker
  import trs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  output int                          mismatches,
  output int                          pending
);

  typedef struct packed {
    logic [63:0] cc;
    logic [63:0] cs;
    logic [63:0] ss;
    logic        zero_len;
    logic        sat;
  } stiffness_t;

  stiffness_t        stiffness_q[$];
  logic [CFG_W-1:0]  young_e;
  logic [CFG_W-1:0]  area_a;

  // magnitude of (q * 2^F + f) * m / 2^30, rounded half up, clipped, signed
  function automatic logic [63:0] scale_entry(input logic [63:0] q, input logic [63:0] f,
                                              input logic [63:0] m, input logic neg,
                                              inout logic sat);
    logic [127:0] p;
    logic [127:0] limit;
    logic [63:0]  mag;
    p = (128'(q) * 128'(m)) << FRAC_BITS;
    p = p + 128'(f) * 128'(m) + (128'(1) << 29);
    p = p >> 30;
    limit = neg ? (128'(1) << 63) : ((128'(1) << 63) - 128'(1));
    if (p > limit) begin
      sat = 1'b1;
      mag = limit[63:0];
    end else begin
      mag = p[63:0];
    end
    return neg ? 64'd0 - mag : mag;
  endfunction

  function automatic stiffness_t element_stiffness(input logic [IN_TDATA_W-1:0] beat);
    logic [32:0]  dx, dy, adx, ady;
    logic [127:0] sq, t;
    logic [63:0]  len, cm, sm, mcc, mcs, mss, ea, qt, fr;
    logic         sat, cs_neg;
    stiffness_t   r;
    dx = {beat[95], beat[95:64]} - {beat[31], beat[31:0]};
    dy = {beat[127], beat[127:96]} - {beat[63], beat[63:32]};
    adx = dx[32] ? -dx : dx;
    ady = dy[32] ? -dy : dy;
    sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    len = 64'd0;
    for (int b = 33; b >= 0; b--) begin
      t = 128'(len | (64'd1 << b));
      if (t * t <= sq) len = t[63:0];
    end
    r = '0;
    if (len == 64'd0) begin
      r.zero_len = 1'b1;
      return r;
    end
    cm = ((64'(adx) << 30) + len / 2) / len;
    sm = ((64'(ady) << 30) + len / 2) / len;
    mcc = (cm * cm + (64'd1 << 29)) >> 30;
    mcs = (cm * sm + (64'd1 << 29)) >> 30;
    mss = (sm * sm + (64'd1 << 29)) >> 30;
    cs_neg = (dx[32] != dy[32]) && (mcs != 64'd0);
    ea = 64'(young_e) * 64'(area_a);
    qt = ea / len;
    fr = ((ea % len) << FRAC_BITS) / len;
    sat = 1'b0;
    r.cc = scale_entry(qt, fr, mcc, 1'b0, sat);
    r.cs = scale_entry(qt, fr, mcs, cs_neg, sat);
    r.ss = scale_entry(qt, fr, mss, 1'b0, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    stiffness_t want;
    if (rst) begin
      stiffness_q.delete();
      young_e <= CFG_W'(65536);
      area_a  <= CFG_W'(65536);
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_YOUNG) young_e <= cfg_data;
        else if (cfg_index == REG_AREA) area_a <= cfg_data;
      end
      if (s_tvalid && s_tready) stiffness_q = {stiffness_q, element_stiffness(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (stiffness_q.size() == 0) begin
          report("unexpected beat", m_tdata[63:0], 64'd0);
        end else begin
          want = stiffness_q.pop_front();
          if (m_tdata[63:0] !== want.cc) report("stiff_cc", m_tdata[63:0], want.cc);
          if (m_tdata[127:64] !== want.cs) report("stiff_cs", m_tdata[127:64], want.cs);
          if (m_tdata[191:128] !== want.ss) report("stiff_ss", m_tdata[191:128], want.ss);
          if (m_tdata[192] !== want.zero_len)
            report("zero_length", 64'(m_tdata[192]), 64'(want.zero_len));
          if (m_tdata[193] !== want.sat)
            report("saturated", 64'(m_tdata[193]), 64'(want.sat));
        end
      end
    end
    pending = stiffness_q.size();
  end

endmodule

`default_nettype wire

[verif/truss2d_element_stiffness_test.sv]
// Testbench top for the plane truss element stiffness pipeline: drives node
// beats, register writes and result back-pressure, gives the verdict.
// Depends on trs_pkg, truss2d_element_stiffness and truss2d_stiffness_checker.
`timescale 1ns / 100ps
`default_nettype none

module truss2d_element_stiffness_test;
  import trs_pkg::*;

  localparam int DRAIN_CYCLES = 140;     // pipe latency plus margin
  localparam int CYCLE_LIMIT  = 800000;  // generous; slow correct run is far less
  localparam int HOLD_CYCLES  = 400;     // long output stall, fills the pipe

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [0:0]             cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  int mismatches;
  int pending;
  int cycles;
  bit hold_request;    // stimulus asks the sink for one long stall
  bit no_gaps;         // stretches where both sides run flat out

  truss2d_element_stiffness dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  truss2d_stiffness_checker chk (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL truss2d_element_stiffness");
      $finish;
    end
  end

  // Result sink: random stalls, mostly short, a few long, plus one long hold
  // on request while the sender keeps offering.
  int  stall_left;
  bit  hold_done;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (hold_request && !hold_done) begin
      m_tready   <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_gaps) begin
      m_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 63))
        0:       stall_left <= $urandom_range(15, 60);
        1, 2, 3: stall_left <= $urandom_range(1, 4);
        default: ;
      endcase
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Called just after a rising edge; returns after the accepting edge and any gap.
  task automatic send_nodes(input logic [31:0] x1, input logic [31:0] y1,
                            input logic [31:0] x2, input logic [31:0] y2);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {y2, x2, y1, x1};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    gap = 0;
    if (!no_gaps && !hold_request) begin
      case ($urandom_range(0, 15))
        0:                gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
        default:          gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly bars of modest size; some full-range, axis-aligned and
  // coinciding nodes.
  task automatic send_random_bar();
    logic [31:0] x1, y1, x2, y2;
    x1 = $urandom;
    y1 = $urandom;
    case ($urandom_range(0, 19))
      0: begin x2 = x1; y2 = y1; end
      1: begin x2 = $urandom; y2 = y1; end
      2: begin x2 = x1; y2 = $urandom; end
      3, 4, 5, 6: begin x2 = $urandom; y2 = $urandom; end
      7, 8, 9: begin
        x2 = x1 + 32'($signed($urandom_range(0, 15)) - 8);
        y2 = y1 + 32'($signed($urandom_range(0, 15)) - 8);
      end
      default: begin
        x2 = x1 + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        y2 = y1 + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      end
    endcase
    send_nodes(x1, y1, x2, y2);
  endtask

  // extremes: coinciding nodes, full span, each axis, three quadrants, 1 LSB
  task automatic send_directed_bars();
    send_nodes(32'h0, 32'h0, 32'h0, 32'h0);
    send_nodes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_nodes(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_nodes(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_nodes(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_nodes(32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
    send_nodes(32'h0, 32'h0, 32'h0003_0000, 32'hFFFC_0000);
    send_nodes(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001);
    send_nodes(32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001);
    send_nodes(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5679, 32'h9ABC_DEF0);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_YOUNG;
    cfg_data     = '0;
    hold_request = 1'b0;
    no_gaps      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset moduli, then both at their maximum to force clipping
    send_directed_bars();
    drain_pipe();
    write_reg(REG_YOUNG, 32'hFFFF_FFFF);
    write_reg(REG_AREA, 32'hFFFF_FFFF);
    send_directed_bars();

    for (int phase = 0; phase < 5; phase++) begin
      drain_pipe();
      case (phase)
        0: begin write_reg(REG_YOUNG, 32'h0);        write_reg(REG_AREA, $urandom); end
        1: begin write_reg(REG_YOUNG, $urandom);     write_reg(REG_AREA, 32'h0); end
        2: begin write_reg(REG_YOUNG, 32'h0001_0000); write_reg(REG_AREA, 32'h0001_0000); end
        3: begin write_reg(REG_YOUNG, $urandom);     write_reg(REG_AREA, $urandom); end
        default: begin
          write_reg(REG_YOUNG, $urandom_range(1, 255));
          write_reg(REG_AREA, $urandom_range(1, 255));
        end
      endcase
      for (int n = 0; n < 216; n++) begin
        if (n % 72 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (phase == 3 && n == 20) hold_request = 1'b1;   // sender offers every cycle
        if (phase == 3 && n == 180) hold_request = 1'b0;
        send_random_bar();
      end
      no_gaps = 1'b0;
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("PASS truss2d_element_stiffness");
    end else begin
      $display("FAIL truss2d_element_stiffness");
    end
    $finish;
  end

endmodule

`default_nettype wire

[truss2d_element_stiffness.f]
rtl/trs_pkg.sv
rtl/trs_sqrt.sv
rtl/trs_div.sv
rtl/truss2d_element_stiffness.sv
rtl/trs_checker.sv
verif/truss2d_stiffness_checker.sv
verif/truss2d_element_stiffness_test.sv
